[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the blink code LED block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LLBC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define LLBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[design/llbc_pkg.sv]
// ---------------------------------------------------------------------------
// llbc_pkg
// Types and constants for the link latency blink code LED block.
// ---------------------------------------------------------------------------
package llbc_pkg;

	localparam int MODE_W     = 2;
	localparam int INTERVAL_W = 12;
	localparam int LATENCY_W  = 9;
	localparam int TICKS_W    = 16;
	localparam int BLINKS_W   = 5;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = INTERVAL_W + LATENCY_W + 1;

	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 12'd3200;
	localparam logic [LATENCY_W-1:0]  LATENCY_MAX  = 9'd499;

	// Reset values of the configuration registers.
	localparam logic [TICKS_W-1:0]  ON_TICKS_RST        = 16'd60;
	localparam logic [TICKS_W-1:0]  GAP_TICKS_RST       = 16'd60;
	localparam logic [TICKS_W-1:0]  SETTLE_TICKS_RST    = 16'd400;
	localparam logic [BLINKS_W-1:0] BOOT_COUNT_RST      = 5'd15;
	localparam logic [TICKS_W-1:0]  POST_BOOT_TICKS_RST = 16'd600;

	// Bucket value in ms = floor(p * 5 / 4) with p = iv_clamp * lt_plus.
	// floor(5p/4) <= T  <=>  p <= floor((4T + 3) / 5), so compare p directly.
	localparam int MS_NUM = 5;
	localparam int MS_DEN = 4;
	localparam int P_LIM1 = (MS_DEN * 10  + MS_DEN - 1) / MS_NUM;
	localparam int P_LIM2 = (MS_DEN * 20  + MS_DEN - 1) / MS_NUM;
	localparam int P_LIM3 = (MS_DEN * 50  + MS_DEN - 1) / MS_NUM;
	localparam int P_LIM4 = (MS_DEN * 100 + MS_DEN - 1) / MS_NUM;

	typedef enum logic [MODE_W-1:0] {
		EV_TICK    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_PARAMS  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_BOOT_ON   = 3'd0,
		PH_BOOT_GAP  = 3'd1,
		PH_POST_BOOT = 3'd2,
		PH_IDLE      = 3'd3,
		PH_READ_ON   = 3'd4,
		PH_READ_GAP  = 3'd5,
		PH_SETTLE    = 3'd6
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ON_TICKS        = 3'd0,
		CFG_GAP_TICKS       = 3'd1,
		CFG_SETTLE_TICKS    = 3'd2,
		CFG_BOOT_COUNT      = 3'd3,
		CFG_POST_BOOT_TICKS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [TICKS_W-1:0]  on_ticks;
		logic [TICKS_W-1:0]  gap_ticks;
		logic [TICKS_W-1:0]  settle_ticks;
		logic [BLINKS_W-1:0] boot_count;
		logic [TICKS_W-1:0]  post_boot_ticks;
	} cfg_t;

	typedef struct packed {
		mode_t                 mode;
		logic [INTERVAL_W-1:0] conn_interval;
		logic [LATENCY_W-1:0]  slave_latency;
	} ev_t;

endpackage

[design/llbc_ev_if.sv]
// ---------------------------------------------------------------------------
// llbc_ev_if
// Event channel: tick, key and link parameter transactions.
// ---------------------------------------------------------------------------
interface llbc_ev_if import llbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [INTERVAL_W-1:0] conn_interval;
	logic [LATENCY_W-1:0]  slave_latency;

	modport source (output valid, mode, conn_interval, slave_latency, input ready);
	modport sink   (input valid, mode, conn_interval, slave_latency, output ready);
endinterface

[design/llbc_led_if.sv]
// ---------------------------------------------------------------------------
// llbc_led_if
// Result channel: LED level after each event.
// ---------------------------------------------------------------------------
interface llbc_led_if;
	logic valid;
	logic ready;
	logic led_on;

	modport source (output valid, led_on, input ready);
	modport sink   (input valid, led_on, output ready);
endinterface

[design/llbc_cfg_if.sv]
// ---------------------------------------------------------------------------
// llbc_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface llbc_cfg_if import llbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[design/llbc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// llbc_cfg_regs
// Timing and boot count registers, written through the config channel.
// ---------------------------------------------------------------------------
module llbc_cfg_regs import llbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks        <= ON_TICKS_RST;
			cfg_q.gap_ticks       <= GAP_TICKS_RST;
			cfg_q.settle_ticks    <= SETTLE_TICKS_RST;
			cfg_q.boot_count      <= BOOT_COUNT_RST;
			cfg_q.post_boot_ticks <= POST_BOOT_TICKS_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_ON_TICKS:        cfg_q.on_ticks        <= wr_data[TICKS_W-1:0];
				CFG_GAP_TICKS:       cfg_q.gap_ticks       <= wr_data[TICKS_W-1:0];
				CFG_SETTLE_TICKS:    cfg_q.settle_ticks    <= wr_data[TICKS_W-1:0];
				CFG_BOOT_COUNT:      cfg_q.boot_count      <= wr_data[BLINKS_W-1:0];
				CFG_POST_BOOT_TICKS: cfg_q.post_boot_ticks <= wr_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/llbc_count.sv]
// ---------------------------------------------------------------------------
// llbc_count
// Maps the link parameters to a blink count of 1 to 5.
// ---------------------------------------------------------------------------
module llbc_count import llbc_pkg::*; (
	input  logic [INTERVAL_W-1:0] conn_interval,
	input  logic [LATENCY_W-1:0]  slave_latency,
	output logic [CNT_W-1:0]      count
);

	logic [INTERVAL_W-1:0] iv_clamp;
	logic [LATENCY_W-1:0]  lt_clamp;
	logic [LATENCY_W:0]    lt_plus;
	logic [PROD_W-1:0]     prod;

	assign iv_clamp = (conn_interval > INTERVAL_MAX) ? INTERVAL_MAX : conn_interval;
	assign lt_clamp = (slave_latency > LATENCY_MAX) ? LATENCY_MAX : slave_latency;
	assign lt_plus  = {1'b0, lt_clamp} + (LATENCY_W+1)'(1);
	assign prod     = PROD_W'(iv_clamp) * PROD_W'(lt_plus);

	// 10 / 20 / 50 / 100 ms buckets, folded into thresholds on the product
	always_comb begin
		if (prod <= PROD_W'(P_LIM1))      count = CNT_W'(1);
		else if (prod <= PROD_W'(P_LIM2)) count = CNT_W'(2);
		else if (prod <= PROD_W'(P_LIM3)) count = CNT_W'(3);
		else if (prod <= PROD_W'(P_LIM4)) count = CNT_W'(4);
		else                              count = CNT_W'(5);
	end

endmodule

[design/llbc_core.sv]
// ---------------------------------------------------------------------------
// llbc_core
// Blink phase sequencer and LED result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module llbc_core import llbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ev_t              ev,
	input  logic [CNT_W-1:0] new_count,
	input  cfg_t             cfg,
	output logic             led_on
);

	phase_t               phase_q, phase_d;
	logic [TICKS_W-1:0]   time_q, time_d;
	logic [BLINKS_W-1:0]  blinks_q, blinks_d;
	logic                 pend_q, pend_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 led_q, led_d;

	// Next state: event first, then start a reading if idle with a trigger.
	always_comb begin
		phase_d  = phase_q;
		time_d   = time_q;
		blinks_d = blinks_q;
		pend_d   = pend_q;
		cnt_d    = cnt_q;
		case (ev.mode)
			EV_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (time_q > TICKS_W'(1)) begin
						time_d = time_q - TICKS_W'(1);
					end else begin
						case (phase_q)
							PH_BOOT_ON: begin
								phase_d = PH_BOOT_GAP;
								time_d  = cfg.gap_ticks;
							end
							PH_BOOT_GAP: begin
								if (blinks_q > BLINKS_W'(1)) begin
									blinks_d = blinks_q - BLINKS_W'(1);
									phase_d  = PH_BOOT_ON;
									time_d   = cfg.on_ticks;
								end else begin
									blinks_d = '0;
									phase_d  = PH_POST_BOOT;
									time_d   = cfg.post_boot_ticks;
								end
							end
							PH_READ_ON: begin
								if (blinks_q > BLINKS_W'(1)) begin
									blinks_d = blinks_q - BLINKS_W'(1);
									phase_d  = PH_READ_GAP;
									time_d   = cfg.gap_ticks;
								end else begin
									blinks_d = '0;
									phase_d  = PH_SETTLE;
									time_d   = cfg.settle_ticks;
								end
							end
							PH_READ_GAP: begin
								phase_d = PH_READ_ON;
								time_d  = cfg.on_ticks;
							end
							default: begin
								phase_d = PH_IDLE;
								time_d  = '0;
							end
						endcase
					end
				end
			end
			EV_PRESS: begin
				pend_d = 1'b1;
			end
			EV_PARAMS: begin
				pend_d = 1'b1;
				cnt_d  = new_count;
			end
			default: ;
		endcase
		if (phase_d == PH_IDLE && pend_d) begin
			pend_d   = 1'b0;
			blinks_d = BLINKS_W'(cnt_d);
			phase_d  = PH_READ_ON;
			time_d   = cfg.on_ticks;
		end
	end

	// Output decode on the next phase
	always_comb begin
		led_d = (phase_d == PH_BOOT_ON) || (phase_d == PH_READ_ON);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BOOT_ON;
			time_q   <= ON_TICKS_RST;
			blinks_q <= BOOT_COUNT_RST;
			pend_q   <= 1'b0;
			cnt_q    <= CNT_W'(1);
		end else if (adv) begin
			phase_q  <= phase_d;
			time_q   <= time_d;
			blinks_q <= blinks_d;
			pend_q   <= pend_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			led_q <= led_d;
		end
	end

	assign led_on = led_q;

	`LLBC_ASSERT(a_no_idle_pend, clk, arst_n, !(phase_q == PH_IDLE && pend_q), "trigger left pending while idle")
	`LLBC_ASSERT(a_read_blinks, clk, arst_n, !((phase_q == PH_READ_ON || phase_q == PH_READ_GAP) && blinks_q == '0), "reading with no blinks left")
	`LLBC_ASSERT(a_cnt_range, clk, arst_n, (cnt_q != '0) && (cnt_q <= CNT_W'(5)), "blink count out of range")
	`LLBC_ASSERT_NEXT(a_hold, clk, arst_n, !adv, $stable(phase_q) && $stable(time_q) && $stable(pend_q), "state moved without an event")
	`LLBC_ASSERT_NEXT(a_led_phase, clk, arst_n, adv, led_q == (phase_q == PH_BOOT_ON || phase_q == PH_READ_ON), "LED does not match phase")

endmodule

[design/link_latency_blink_code_led_top.sv]
// ---------------------------------------------------------------------------
// link_latency_blink_code_led_top
// Status LED blink code generator showing worst-case link latency.
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                              | transaction
//  ---------+-----+--------------------------------------+----------------------
//  ev       | in  | mode, conn_interval, slave_latency   | valid & ready
//  led      | out | led_on                               | valid & ready
//  cfg      | in  | index, data                          | valid & ready (ready=1)
//
//  Throughput: one event per clock while led.ready is high; the accepting edge
//    loads the input register, and the event's LED level is loaded into the
//    result register when it advances, then offered on the led channel.
//  The combinational state update (compare/decrement of time_q, clamp and
//    12x10 multiply for the blink count) sets the per-event work.
//  Reset: asynchronous, arst_n low. Starts in the boot signature, first
//    blink lit, with all register defaults; no clearing pass.
//  Stalls: led.ready low while the result register is full freezes it and the
//    input register; ev.ready stays high while the input register is empty.
//
// Config writes are taken any cycle; they must land only while no event
// is in flight.
// ---------------------------------------------------------------------------
module link_latency_blink_code_led_top import llbc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	llbc_ev_if.sink   ev,
	llbc_led_if.source led,
	llbc_cfg_if.sink  cfg
);

	// Input register stage
	ev_t              ev_s1;
	logic             vld_s1;
	// Result register valid
	logic             out_vld_q;
	logic             adv;
	cfg_t             cfg_val;
	logic [CNT_W-1:0] new_count;

	// An event moves into the core when the result slot is free or draining.
	assign adv      = vld_s1 && (!out_vld_q || led.ready);
	assign ev.ready = !vld_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ev.ready) begin
			vld_s1 <= ev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.ready && ev.valid) begin
			ev_s1.mode          <= mode_t'(ev.mode);
			ev_s1.conn_interval <= ev.conn_interval;
			ev_s1.slave_latency <= ev.slave_latency;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (led.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	llbc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	llbc_count u_count (
		.conn_interval (ev_s1.conn_interval),
		.slave_latency (ev_s1.slave_latency),
		.count         (new_count)
	);

	llbc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ev        (ev_s1),
		.new_count (new_count),
		.cfg       (cfg_val),
		.led_on    (led.led_on)
	);

	assign led.valid = out_vld_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link latency blink code LED block: a directed
// walk through boot, readings and blink count boundaries, then random event
// streams under several register settings, with every LED level compared
// against its directed value or an in-bench model of the blink sequencer.
// ---------------------------------------------------------------------------
module tb_top;
	import llbc_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 5;
	localparam int CONFIG_GUARD   = 4;    // block holds at most two events in flight
	localparam int END_GUARD      = 8;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	// Index nobody decodes; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

	// Upper bounds (ms) of the first four blink counts of a reading.
	localparam int unsigned WAIT_BOUNDS_MS [4] = '{10, 20, 50, 100};

	// One directed step: an event, how many times to send it, and, where it
	// is obvious, the LED level that must come back.
	typedef struct packed {
		mode_t                 mode;
		logic [INTERVAL_W-1:0] interval;
		logic [LATENCY_W-1:0]  latency;
		logic [7:0]            repeats;
		logic                  known;
		logic                  led;
	} stim_row_t;

	localparam int NUM_ROWS = 25;
	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// boot signature, first blink lit straight out of reset
		'{EV_TICK,    12'd0,    9'd0,   8'd1,  1'b1, 1'b1},
		'{EV_RELEASE, 12'hFFF,  9'h1FF, 8'd1,  1'b1, 1'b1},   // release ignored
		'{EV_PRESS,   12'd0,    9'd0,   8'd1,  1'b1, 1'b1},   // trigger held over boot
		'{EV_TICK,    12'd0,    9'd0,   8'd58, 1'b0, 1'b0},
		'{EV_TICK,    12'd0,    9'd0,   8'd1,  1'b1, 1'b0},   // 60th tick ends boot blink
		// rest of boot; the held press gives one blink, no parameters yet
		'{EV_TICK,    12'd0,    9'd0,   8'd50, 1'b0, 1'b0},
		// idle: each update starts its reading in the same transaction
		'{EV_PARAMS,  12'd0,    9'd0,   8'd1,  1'b1, 1'b1},
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		'{EV_PARAMS,  12'd8,    9'd0,   8'd1,  1'b1, 1'b1},   // 10 ms, last of one blink
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		'{EV_PARAMS,  12'd9,    9'd0,   8'd1,  1'b1, 1'b1},   // 11 ms, two blinks
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		'{EV_PARAMS,  12'd17,   9'd0,   8'd1,  1'b1, 1'b1},   // 21 ms, three blinks
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		'{EV_PARAMS,  12'd41,   9'd0,   8'd1,  1'b1, 1'b1},   // 51 ms, four blinks
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		'{EV_PARAMS,  12'd81,   9'd0,   8'd1,  1'b1, 1'b1},   // 101 ms, five blinks
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		'{EV_PARAMS,  12'hFFF,  9'h1FF, 8'd1,  1'b1, 1'b1},   // both fields clamped
		'{EV_TICK,    12'd0,    9'd0,   8'd12, 1'b0, 1'b0},
		// press reuses held parameters; a second press mid-reading is held as one pending trigger
		'{EV_PRESS,   12'd0,    9'd0,   8'd1,  1'b1, 1'b1},
		'{EV_PRESS,   12'd0,    9'd0,   8'd1,  1'b1, 1'b1},
		'{EV_TICK,    12'd0,    9'd0,   8'd20, 1'b0, 1'b0},
		'{EV_PARAMS,  12'd3200, 9'd499, 8'd1,  1'b0, 1'b0},
		'{EV_RELEASE, 12'd0,    9'd0,   8'd1,  1'b0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	llbc_ev_if  ev_bus ();
	llbc_led_if led_bus ();
	llbc_cfg_if cfg_bus ();

	link_latency_blink_code_led_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev_bus),
		.led    (led_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Blink sequencer model: own copy of the registers and the state.
	// -----------------------------------------------------------------------
	cfg_t                  cur_cfg;
	phase_t                m_phase;
	logic [TICKS_W-1:0]    m_left;       // ticks still to spend in m_phase
	logic [BLINKS_W-1:0]   m_blinks;
	logic                  m_pending;
	logic                  m_have_params;
	logic [INTERVAL_W-1:0] m_interval;
	logic [LATENCY_W-1:0]  m_latency;

	logic led_level_q [$];    // LED levels still owed by the block
	int unsigned mismatches = 0;

	task automatic model_reset();
		cur_cfg = {ON_TICKS_RST, GAP_TICKS_RST, SETTLE_TICKS_RST, BOOT_COUNT_RST,
			POST_BOOT_TICKS_RST};
		m_phase = PH_BOOT_ON;
		m_left = ON_TICKS_RST;
		m_blinks = BOOT_COUNT_RST;
		m_pending = 1'b0;
		m_have_params = 1'b0;
		m_interval = '0;
		m_latency = '0;
	endtask

	task automatic load_phase(input phase_t ph, input logic [TICKS_W-1:0] ticks);
		m_phase = ph;
		m_left = ticks;
	endtask

	// Blink count of a reading: one, plus one per ms bound that the rounded-down wait exceeds.
	function automatic logic [BLINKS_W-1:0] reading_blinks();
		int unsigned wait_ms;
		logic [BLINKS_W-1:0] n;
		n = 1;
		if (m_have_params) begin
			wait_ms = (32'(m_interval) * (32'(m_latency) + 1) * 5) / 4;
			foreach (WAIT_BOUNDS_MS[k])
				if (wait_ms > WAIT_BOUNDS_MS[k])
					n++;
		end
		return n;
	endfunction

	task automatic end_of_phase();
		case (m_phase)
			PH_BOOT_ON: load_phase(PH_BOOT_GAP, cur_cfg.gap_ticks);
			PH_BOOT_GAP: begin
				if (m_blinks > 1) begin
					m_blinks--;
					load_phase(PH_BOOT_ON, cur_cfg.on_ticks);
				end else begin
					m_blinks = '0;
					load_phase(PH_POST_BOOT, cur_cfg.post_boot_ticks);
				end
			end
			PH_READ_ON: begin
				if (m_blinks > 1) begin
					m_blinks--;
					load_phase(PH_READ_GAP, cur_cfg.gap_ticks);
				end else begin
					m_blinks = '0;
					load_phase(PH_SETTLE, cur_cfg.settle_ticks);
				end
			end
			PH_READ_GAP: load_phase(PH_READ_ON, cur_cfg.on_ticks);
			default: load_phase(PH_IDLE, '0);
		endcase
	endtask

	task automatic step_led_model(input ev_t e, output logic lit);
		case (e.mode)
			EV_TICK: begin
				// a load of 0 counts as 1: expiry on the first tick
				if (m_phase != PH_IDLE) begin
					if (m_left > 1)
						m_left--;
					else
						end_of_phase();
				end
			end
			EV_PRESS: m_pending = 1'b1;
			EV_PARAMS: begin
				m_interval = (e.conn_interval > INTERVAL_MAX) ? INTERVAL_MAX : e.conn_interval;
				m_latency = (e.slave_latency > LATENCY_MAX) ? LATENCY_MAX : e.slave_latency;
				m_have_params = 1'b1;
				m_pending = 1'b1;
			end
			default: ;
		endcase
		// idle with a trigger: first blink lit in this same transaction
		if (m_phase == PH_IDLE && m_pending) begin
			m_pending = 1'b0;
			m_blinks = reading_blinks();
			load_phase(PH_READ_ON, cur_cfg.on_ticks);
		end
		lit = (m_phase == PH_BOOT_ON || m_phase == PH_READ_ON);
	endtask

	// -----------------------------------------------------------------------
	// Drivers. Everything is driven by NBA right after a rising edge and
	// handshakes are sampled at the edge, so all reads see pre-edge values.
	// -----------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			CFG_ON_TICKS:        cur_cfg.on_ticks = val;
			CFG_GAP_TICKS:       cur_cfg.gap_ticks = val;
			CFG_SETTLE_TICKS:    cur_cfg.settle_ticks = val;
			CFG_BOOT_COUNT:      cur_cfg.boot_count = val[BLINKS_W-1:0];
			CFG_POST_BOOT_TICKS: cur_cfg.post_boot_ticks = val;
			default: ;
		endcase
	endtask

	// Back-to-back writes keep valid high; it drops only after the last one.
	task automatic program_regs(input cfg_t c, input bit poke_spare);
		write_reg(CFG_ON_TICKS, c.on_ticks);
		write_reg(CFG_GAP_TICKS, c.gap_ticks);
		write_reg(CFG_SETTLE_TICKS, c.settle_ticks);
		// junk above the 5-bit count must be dropped
		write_reg(CFG_BOOT_COUNT, {(CFG_DATA_W - BLINKS_W)'($urandom), c.boot_count});
		write_reg(CFG_POST_BOOT_TICKS, c.post_boot_ticks);
		if (poke_spare)
			write_reg(CFG_SPARE_IDX, '1);
		cfg_bus.valid <= 1'b0;
	endtask

	// Offer one event and hold it until taken; valid is left high so the
	// caller can chain the next event in the same step.
	task automatic send_event(input ev_t e, input logic known, input logic known_led);
		logic lit;
		ev_bus.valid <= 1'b1;
		ev_bus.mode <= e.mode;
		ev_bus.conn_interval <= e.conn_interval;
		ev_bus.slave_latency <= e.slave_latency;
		@(posedge clk);
		while (!ev_bus.ready)
			@(posedge clk);
		step_led_model(e, lit);
		led_level_q.push_back(known ? known_led : lit);
	endtask

	// Register writes only with nothing in flight.
	task automatic drain_for_config();
		while (led_level_q.size() != 0)
			@(posedge clk);
		repeat (CONFIG_GUARD) @(posedge clk);
	endtask

	function automatic ev_t random_event();
		ev_t e;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		e.conn_interval = INTERVAL_W'($urandom);
		e.slave_latency = LATENCY_W'($urandom);
		if (pick < 70)
			e.mode = EV_TICK;
		else if (pick < 80)
			e.mode = EV_PRESS;
		else if (pick < 86)
			e.mode = EV_RELEASE;
		else begin
			e.mode = EV_PARAMS;
			case ($urandom_range(0, 2))
				0: begin
					// around the blink count boundaries
					e.conn_interval = INTERVAL_W'($urandom_range(0, 90));
					e.slave_latency = LATENCY_W'($urandom_range(0, 1));
				end
				1: begin
					e.conn_interval = INTERVAL_W'($urandom_range(0, INTERVAL_MAX));
					e.slave_latency = LATENCY_W'($urandom_range(0, LATENCY_MAX));
				end
				default: ;    // full width, often above range
			endcase
		end
		return e;
	endfunction

	function automatic cfg_t pick_durations(input int unsigned lo, input int unsigned hi);
		cfg_t c;
		c.on_ticks = TICKS_W'($urandom_range(lo, hi));
		c.gap_ticks = TICKS_W'($urandom_range(lo, hi));
		c.settle_ticks = TICKS_W'($urandom_range(lo, hi));
		c.boot_count = BLINKS_W'($urandom);
		c.post_boot_ticks = TICKS_W'($urandom_range(lo, hi));
		return c;
	endfunction

	// -----------------------------------------------------------------------
	// LED side: random stall bursts, plus one long hold-off on request.
	// -----------------------------------------------------------------------
	bit sink_idle_en = 1'b1;
	bit holdoff_req = 1'b0;
	int stall_left = 0;

	initial begin
		led_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				stall_left = HOLDOFF_CYCLES;
			end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 18);
			if (stall_left > 0) begin
				stall_left--;
				led_bus.ready <= 1'b0;
			end else
				led_bus.ready <= 1'b1;
		end
	end

	// -----------------------------------------------------------------------
	// Checker: every LED transaction against the oldest owed level.
	// -----------------------------------------------------------------------
	logic owed_led;

	always @(posedge clk) begin
		if (arst_n && led_bus.valid && led_bus.ready) begin
			if (led_level_q.size() == 0) begin
				$display("%0t: LED transaction with nothing owed: expected none, got %0b",
					$time, led_bus.led_on);
				mismatches++;
			end else begin
				owed_led = led_level_q.pop_front();
				if (led_bus.led_on !== owed_led) begin
					$display("%0t: led_on mismatch: expected %0b, got %0b",
						$time, owed_led, led_bus.led_on);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on any channel.
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if ((ev_bus.valid && ev_bus.ready) || (led_bus.valid && led_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("link_latency_blink_code_led_top test failed");
			$finish;
		end
	end

	// One random phase: new register set, then a stream of events. Gaps on
	// both sides switch on and off in segments so some stretches run flat out.
	task automatic run_random(input cfg_t c, input int n_items, input bit gaps_on,
			input bit squeeze);
		int gap_pct;
		gap_pct = 0;
		drain_for_config();
		program_regs(c, 1'b0);
		// long LED hold-off while events keep coming: fills the block
		if (squeeze)
			holdoff_req = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				gap_pct = (gaps_on && !(squeeze && i == 0) && $urandom_range(0, 3) != 0) ? 12 : 0;
				sink_idle_en = gaps_on && $urandom_range(0, 3) != 0;
			end
			send_event(random_event(), 1'b0, 1'b0);
			if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
				ev_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
		ev_bus.valid <= 1'b0;
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		stim_row_t row;
		ev_t       e;

		arst_n <= 1'b0;
		ev_bus.valid <= 1'b0;
		ev_bus.mode <= EV_TICK;
		ev_bus.conn_interval <= '0;
		ev_bus.slave_latency <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_ON_TICKS;
		cfg_bus.data <= '0;
		model_reset();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest durations so boot ends quickly; the first boot blink
		// still runs its reset length of 60 ticks. Count 0 has no effect
		// once the signature has started.
		program_regs({16'd1, 16'd1, 16'd1, 5'd0, 16'd1}, 1'b1);

		foreach (DIRECTED_ROWS[r]) begin
			row = DIRECTED_ROWS[r];
			e.mode = row.mode;
			e.conn_interval = row.interval;
			e.slave_latency = row.latency;
			repeat (row.repeats) send_event(e, row.known, row.led);
		end
		ev_bus.valid <= 1'b0;

		run_random(pick_durations(1, 6), 135, 1'b1, 1'b0);
		// zero durations must act as one tick; LED hold-off in this phase
		run_random({16'd0, 16'd0, 16'd0, 5'd31, 16'd0}, 135, 1'b1, 1'b1);
		run_random(pick_durations(8, 20), 135, 1'b1, 1'b0);
		run_random(pick_durations(1, 3), 135, 1'b1, 1'b0);
		run_random(pick_durations(1, 6), 135, 1'b1, 1'b0);
		// top of every range, no idling on either side
		run_random({16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF}, 150, 1'b0, 1'b0);

		while (led_level_q.size() != 0)
			@(posedge clk);
		repeat (END_GUARD) @(posedge clk);

		if (mismatches == 0 && led_level_q.size() == 0)
			$display("link_latency_blink_code_led_top test passed");
		else
			$display("link_latency_blink_code_led_top test failed");
		$finish;
	end

endmodule

[link_latency_blink_code_led_top.f]
+incdir+design
design/llbc_pkg.sv
design/llbc_ev_if.sv
design/llbc_led_if.sv
design/llbc_cfg_if.sv
design/llbc_cfg_regs.sv
design/llbc_count.sv
design/llbc_core.sv
design/link_latency_blink_code_led_top.sv
sim/tb_top.sv
